// ===== rtl/core/stable_softmax_defines.svh =====
// Assertion macros for the stable softmax block.
// Used only by the top level; no other dependencies.
`ifndef STABLE_SOFTMAX_DEFINES_SVH
`define STABLE_SOFTMAX_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define SSM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define SSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSM_ASSERT_NOW(name, ante, cons, msg)
`define SSM_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ssm_pkg.sv =====
// Shared types, constants and the exp table for the stable softmax block.
// No dependencies.
package ssm_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int DATA_W      = 16;
  localparam int EXP_W       = 17;
  localparam int DIV_STEPS   = 17;
  localparam logic [8:0] LOG2E_Q8 = 9'd369;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic acc;
    logic div_init;
    logic div_step;
    logic idx_inc;
    logic idx_clr;
    logic vec_clr;
  } ssm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic div_last;
  } ssm_sts_t;

  // 2^(-j/16) in Q1.16, j = 0..16.
  function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] j);
    logic [EXP_W-1:0] r;
    unique case (j)
      5'd0:  r = 17'd65536;
      5'd1:  r = 17'd62757;
      5'd2:  r = 17'd60097;
      5'd3:  r = 17'd57549;
      5'd4:  r = 17'd55109;
      5'd5:  r = 17'd52772;
      5'd6:  r = 17'd50535;
      5'd7:  r = 17'd48393;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd44376;
      5'd10: r = 17'd42495;
      5'd11: r = 17'd40693;
      5'd12: r = 17'd38968;
      5'd13: r = 17'd37316;
      5'd14: r = 17'd35734;
      5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/stable_softmax.sv =====
// Stable softmax over one vector of signed Q8.8 elements: elements load at one
// per cycle while the block is in its load phase; after the element marked
// last, a pass through the read and three exp states per stored element builds
// the exp sum, then each element goes through the exp pipeline and a 17-step
// restoring divider before its Q0.16 result is offered, and the result is held
// until the result transaction is taken.
// Top level of the stable softmax block; joins controller and datapath.
// Depends on ssm_pkg, ssm_ctrl, ssm_dp and stable_softmax_defines.svh.
`include "stable_softmax_defines.svh"
module stable_softmax #(
  parameter int MAX_LEN = ssm_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ssm_pkg::DATA_W-1:0] value,
  input  logic                              is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssm_pkg::DATA_W-1:0]        probability,
  output logic                              end_of_vector,
  output logic                              truncated
);
  import ssm_pkg::*;

  ssm_cmd_t cmd;
  ssm_sts_t sts;

  // Sequencing of load, sum, divide and result phases.
  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  ssm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .sts           (sts),
    .probability   (probability),
    .end_of_vector (end_of_vector),
    .truncated     (truncated)
  );

  // No input transaction is taken while a result is offered.
  `SSM_ASSERT_NOW(a_no_load_while_out, out_valid, in_stall, "input taken during output")
  // The last element of a vector starts the busy phase.
  `SSM_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && is_last, in_stall,
    "input taken right after last element")
  // The final result closes the vector.
  `SSM_ASSERT_NEXT(a_idle_after_end, out_valid && !out_stall && end_of_vector, !out_valid,
    "result offered after end of vector")

endmodule

// ===== rtl/core/ssm_ctrl.sv =====
// Controller state machine for the stable softmax block.
// Depends on ssm_pkg for the command and status types.
module ssm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             is_last,
  input  logic             out_stall,
  input  ssm_pkg::ssm_sts_t sts,
  output logic             in_stall,
  output logic             out_valid,
  output ssm_pkg::ssm_cmd_t cmd
);
  import ssm_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RD   = 6'b000010,
    S_EXPA = 6'b000100,
    S_EXPB = 6'b001000,
    S_EXPC = 6'b010000,
    S_DIV  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   emit, emit_next;
  logic   sum_phase, sum_phase_next;

  // State register; emit marks a held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      emit      <= 1'b0;
      sum_phase <= 1'b0;
    end else begin
      state     <= state_next;
      emit      <= emit_next;
      sum_phase <= sum_phase_next;
    end
  end

  assign in_stall  = (state != S_LOAD) || emit;
  assign out_valid = emit;

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    emit_next      = emit;
    sum_phase_next = sum_phase;
    cmd            = '0;
    if (emit) begin
      // Wait for the result transaction, then move to the next element, or clear the vector after the last.
      if (!out_stall) begin
        emit_next = 1'b0;
        if (sts.idx_last) begin
          cmd.vec_clr = 1'b1;
          state_next  = S_LOAD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            cmd.load = 1'b1;
            if (is_last) begin
              sum_phase_next = 1'b1;
              state_next     = S_RD;
            end
          end
        end
        S_RD:   state_next = S_EXPA;
        S_EXPA: state_next = S_EXPB;
        S_EXPB: state_next = S_EXPC;
        S_EXPC: begin
          if (sum_phase) begin
            cmd.acc = 1'b1;
            if (sts.idx_last) begin
              cmd.idx_clr    = 1'b1;
              sum_phase_next = 1'b0;
            end else begin
              cmd.idx_inc = 1'b1;
            end
            state_next = S_RD;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = S_DIV;
          end
        end
        S_DIV: begin
          cmd.div_step = 1'b1;
          if (sts.div_last) begin
            emit_next = 1'b1;
          end
        end
        default: state_next = S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/core/ssm_dp.sv =====
// Datapath of the stable softmax block: element memory, running maximum,
// exp approximation, exp sum and a restoring divider. Depends on ssm_pkg.
module ssm_dp #(
  parameter int MAX_LEN = ssm_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssm_pkg::ssm_cmd_t             cmd,
  input  logic signed [ssm_pkg::DATA_W-1:0] value,
  output ssm_pkg::ssm_sts_t             sts,
  output logic [ssm_pkg::DATA_W-1:0]    probability,
  output logic                          end_of_vector,
  output logic                          truncated
);
  import ssm_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = EXP_W + IDX_W;
  localparam int DC_W  = $clog2(DIV_STEPS);

  logic signed [DATA_W-1:0] mem [MAX_LEN];
  logic signed [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] run_max;
  logic                     ovf;
  logic [SUM_W-1:0]         exp_sum;
  logic [IDX_W-1:0]         idx;

  logic [DATA_W:0]          below_max;
  logic [DATA_W+8:0]        prod_y;
  logic [EXP_W-1:0]         y;
  logic [4:0]               h;
  logic [EXP_W-1:0]         t0, t1, delta;
  logic [DATA_W-1:0]        interp;
  logic [EXP_W-1:0]         m;
  logic                     k_big;
  logic [4:0]               k_sh;
  logic [EXP_W-1:0]         e;

  logic [SUM_W:0]           rem, trial, rem_next;
  logic [EXP_W-1:0]         quo, quo_next;
  logic [DC_W-1:0]          div_cnt;
  logic                     fits;

  // Element memory: written while loading, read at the element index.
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CNT_W'(MAX_LEN))) begin
      mem[count[IDX_W-1:0]] <= value;
    end
    rd_data <= mem[idx];
  end

  // Vector state: count, maximum, drop flag, exp sum, element index.
  always_ff @(posedge clk) begin
    if (rst || cmd.vec_clr) begin
      count   <= '0;
      run_max <= 16'sh8000;
      ovf     <= 1'b0;
      exp_sum <= '0;
      idx     <= '0;
    end else begin
      if (cmd.load) begin
        if (count < CNT_W'(MAX_LEN)) begin
          count <= count + 1'b1;
          if (value > run_max) begin
            run_max <= value;
          end
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.acc) begin
        exp_sum <= exp_sum + SUM_W'(e);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign sts.idx_last = ((CNT_W'(idx) + 1'b1) == count);

  // First exp stage: distance below the maximum times log2(e).
  assign below_max = 17'(17'(run_max) - 17'(rd_data));
  assign prod_y    = 25'(below_max[DATA_W-1:0]) * 25'(LOG2E_Q8);

  always_ff @(posedge clk) begin
    y <= prod_y[DATA_W+8:8];
  end

  // Second exp stage: table lookup with linear interpolation.
  assign h      = {1'b0, y[7:4]};
  assign t0     = pow2_frac(h);
  assign t1     = pow2_frac(h + 5'd1);
  assign delta  = t0 - t1;
  assign interp = 16'((delta * 17'(y[3:0]) + 17'd8) >> 4);

  always_ff @(posedge clk) begin
    m     <= t0 - 17'(interp);
    k_big <= (y[16:8] >= 9'd17);
    k_sh  <= y[12:8];
  end

  // Third exp stage: scale by the integer power of two, underflow to zero.
  assign e = k_big ? '0 : (m >> k_sh);

  // Restoring divider: one quotient bit per cycle of e * 2^16 / exp_sum.
  assign trial    = (div_cnt == '0) ? rem : {rem[SUM_W-1:0], 1'b0};
  assign fits     = (trial >= {1'b0, exp_sum});
  assign rem_next = fits ? (trial - {1'b0, exp_sum}) : trial;
  assign quo_next = {quo[EXP_W-2:0], fits};
  assign sts.div_last = (div_cnt == DC_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= (SUM_W+1)'(e);
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      quo     <= quo_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Result register, loaded on the last divider step with saturation.
  always_ff @(posedge clk) begin
    if (cmd.div_step && sts.div_last) begin
      probability   <= quo_next[EXP_W-1] ? '1 : quo_next[DATA_W-1:0];
      end_of_vector <= sts.idx_last;
      truncated     <= ovf;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the stable softmax block.
// Depends on ssm_pkg and the stable_softmax top level.
`timescale 1ns / 100ps
module tb;
  import ssm_pkg::*;

  localparam int VEC_CAP = 64;

  // One row of the directed stimulus table.
  typedef struct {
    logic signed [15:0] value;
    logic               is_last;
  } elem_row_t;

  // One predicted softmax result.
  typedef struct {
    logic [15:0] probability;
    logic        end_of_vector;
    logic        truncated;
  } prob_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] value = '0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] probability;
  logic end_of_vector;
  logic truncated;

  int send_idle_pct = 16;
  int recv_idle_pct = 54;
  int mismatch_count = 0;
  int sent_count = 0;

  // Predictor state for the vector being collected.
  logic signed [15:0] vec_store [VEC_CAP];
  int                 vec_len = 0;
  logic signed [15:0] vec_max = -16'sd32768;
  logic               vec_dropped = 1'b0;

  prob_t expected_probs[$];

  localparam int unsigned EXP_TABLE [17] = '{
    65536, 62757, 60097, 57549, 55109, 52772, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  elem_row_t directed_rows[$];

  stable_softmax u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .value(value), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .probability(probability), .end_of_vector(end_of_vector),
    .truncated(truncated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Fixed-point exp(-n) in Q1.16 with n in Q8.8.
  function automatic int unsigned exp_neg_q16(input int unsigned n);
    int unsigned y, k, h, l, m;
    y = (n * 369) >> 8;
    k = y >> 8;
    h = (y & 255) >> 4;
    l = y & 15;
    if (k >= 17) return 0;
    m = EXP_TABLE[h] - (((EXP_TABLE[h] - EXP_TABLE[h+1]) * l + 8) >> 4);
    return m >> k;
  endfunction

  // Fold one accepted element into the vector and predict results on the last.
  task automatic predict_softmax(input logic signed [15:0] x, input logic last);
    longint unsigned total, p;
    prob_t r;
    if (vec_len < VEC_CAP) begin
      vec_store[vec_len] = x;
      vec_len++;
      if (x > vec_max) vec_max = x;
    end else begin
      vec_dropped = 1'b1;
    end
    if (last) begin
      total = 0;
      for (int i = 0; i < vec_len; i++)
        total += exp_neg_q16(32'(int'(vec_max) - int'(vec_store[i])));
      for (int i = 0; i < vec_len; i++) begin
        p = (longint'(exp_neg_q16(32'(int'(vec_max) - int'(vec_store[i])))) << 16) / total;
        r.probability = (p > 65535) ? 16'hFFFF : 16'(p);
        r.end_of_vector = (i == vec_len - 1);
        r.truncated = vec_dropped;
        expected_probs.push_back(r);
      end
      vec_len = 0;
      vec_max = -16'sd32768;
      vec_dropped = 1'b0;
    end
  endtask

  // Drive one transaction and hold it until accepted; the caller or the next
  // transaction decides what in_valid does afterwards.
  task automatic send_element(input logic signed [15:0] x, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= x;
    is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_softmax(x, last);
    sent_count++;
  endtask

  // Random vector: mostly short, some near or past capacity.
  task automatic send_random_vector();
    int len, spread, base;
    case ($urandom_range(9))
      0: len = $urandom_range(66, 64);
      1: len = 1;
      default: len = $urandom_range(8, 2);
    endcase
    spread = $urandom_range(3);
    base = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      logic signed [15:0] v;
      case (spread)
        0: v = 16'($urandom_range(65535));
        1: v = 16'(base + int'($urandom_range(1023)) - 512);
        default: v = 16'(base + int'($urandom_range(63)));
      endcase
      send_element(v, i == len - 1);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_probs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result p=%0d eov=%0b trunc=%0b",
                   probability, end_of_vector, truncated);
      end else begin
        prob_t e;
        e = expected_probs.pop_front();
        if (probability !== e.probability || end_of_vector !== e.end_of_vector ||
            truncated !== e.truncated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp p=%0d eov=%0b trunc=%0b got p=%0d eov=%0b trunc=%0b",
                     e.probability, e.end_of_vector, e.truncated,
                     probability, end_of_vector, truncated);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #20ms;
    $display("stable_softmax regression: fail");
    $finish;
  end

  // Main stimulus.
  initial begin
    // Directed rows: extremes, single element, underflow.
    directed_rows.push_back('{16'sh7FFF, 1'b1});
    directed_rows.push_back('{-16'sd32768, 1'b1});
    directed_rows.push_back('{16'sh7FFF, 1'b0});
    directed_rows.push_back('{-16'sd32768, 1'b1});
    directed_rows.push_back('{16'sd0, 1'b0});
    directed_rows.push_back('{16'sd0, 1'b1});
    directed_rows.push_back('{16'sd256, 1'b0});
    directed_rows.push_back('{16'sd0, 1'b0});
    directed_rows.push_back('{-16'sd256, 1'b0});
    directed_rows.push_back('{16'sh5555, 1'b0});
    directed_rows.push_back('{-16'sh5556, 1'b1});
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Single element: probability saturates to full scale.
    send_element(16'sh7FFF, 1'b1);
    if (expected_probs[0].probability !== 16'hFFFF) mismatch_count++;
    foreach (directed_rows[i]) send_element(directed_rows[i].value, directed_rows[i].is_last);
    // Overflow: 66 elements, dropped last element still triggers output.
    for (int i = 0; i < 66; i++) send_element(16'(i * 97), i == 65);
    in_valid <= 1'b0;
    // Hold off until the block has drained.
    while (expected_probs.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 54; recv_idle_pct = 16; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      while (sent_count < 95 + 105 * (phase + 1)) send_random_vector();
    end
    in_valid <= 1'b0;
    while (expected_probs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("stable_softmax regression: pass");
    else
      $display("stable_softmax regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ssm_pkg.sv
rtl/core/ssm_ctrl.sv
rtl/core/ssm_dp.sv
rtl/core/stable_softmax.sv
tb/sv/tb.sv
